FILE: rtl/plbs_pkg.sv
// Shared types and constants for the price level book side.
// Used by plbs_cell and price_level_book_side_top; no dependencies.
package plbs_pkg;

   localparam int COUNT_W = 4;
   localparam int PRICE_W = 32;
   localparam int QTY_W   = 31;
   localparam int LEVEL_W = 8;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_ADD         = 3'd0;
   localparam logic [CMD_W-1:0] CMD_UPDATE      = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE      = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DELETE_FROM = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE_THRU = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
   localparam logic [STAT_W-1:0] ST_RANGE    = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISMATCH = 2'd2;

   localparam logic [1:0] MODE_HOLD   = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_UPDATE = 2'd2;
   localparam logic [1:0] MODE_REMOVE = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic [COUNT_W-1:0] idx;
      logic [PRICE_W-1:0] price;
      logic [QTY_W-1:0]   qty;
   } cell_ctrl_type;

   function automatic logic [COUNT_W-1:0] eff_depth(input logic [COUNT_W-1:0] md,
                                                    input logic [COUNT_W-1:0] cap);
      logic [COUNT_W-1:0] r;
      if (md == '0) r = COUNT_W'(1);
      else if (md > cap) r = cap;
      else r = md;
      return r;
   endfunction

endpackage

FILE: rtl/plbs_cell.sv
// One book level: price and quantity registers with neighbour shift paths.
// Depends on plbs_pkg for the control struct and mode codes.
module plbs_cell #(
   parameter int POS = 0
) (
   input  logic                          clock,
   input  plbs_pkg::cell_ctrl_type       ctrl,
   input  logic [plbs_pkg::PRICE_W-1:0]  prev_price,
   input  logic [plbs_pkg::QTY_W-1:0]    prev_qty,
   input  logic [plbs_pkg::PRICE_W-1:0]  next_price,
   input  logic [plbs_pkg::QTY_W-1:0]    next_qty,
   output logic [plbs_pkg::PRICE_W-1:0]  price,
   output logic [plbs_pkg::QTY_W-1:0]    qty,
   output logic                          hit
);

   localparam logic [5:0] POS_V = 6'(POS);

   logic [plbs_pkg::PRICE_W-1:0] price_ff, price_in;
   logic [plbs_pkg::QTY_W-1:0]   qty_ff, qty_in;
   logic [5:0]                   idx_w;
   logic                         at_idx;

   assign idx_w  = {2'b00, ctrl.idx};
   assign at_idx = (POS_V == idx_w);

   always_comb begin
      price_in = price_ff;
      qty_in   = qty_ff;
      case (ctrl.mode)
         plbs_pkg::MODE_INSERT: begin
            if (at_idx) begin
               price_in = ctrl.price;
               qty_in   = ctrl.qty;
            end else if (POS_V > idx_w) begin
               price_in = prev_price;
               qty_in   = prev_qty;
            end
         end
         plbs_pkg::MODE_UPDATE: begin
            if (at_idx) qty_in = ctrl.qty;
         end
         plbs_pkg::MODE_REMOVE: begin
            if (POS_V >= idx_w) begin
               price_in = next_price;
               qty_in   = next_qty;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      price_ff <= price_in;
      qty_ff   <= qty_in;
   end

   assign price = price_ff;
   assign qty   = qty_ff;
   assign hit   = at_idx && (price_ff == ctrl.price);

endmodule

FILE: rtl/price_level_book_side_top.sv
// Top level of the price level book side: control, level count and result register.
// Depends on plbs_pkg and plbs_cell.
//
// Usage:
//   Requests enter on req_* (valid/ready) and each gives one result on rsp_*
//   (valid/ready) with status, level count and the top level.
//   A request is taken only when the block is idle. It executes in the EXEC state,
//   except delete_from of N levels, which then shifts the row of cells up one
//   level per cycle in the SHIFT state until N levels are shifted out. The result is
//   loaded into the output register in the REPORT state once that register is free,
//   and rsp_valid rises when it is loaded. A new request is taken only after the result
//   is loaded; the accept, execute, optional shift and report steps run in that order.
//   The output register lets the next request execute while a result waits;
//   when the receiver stalls, that next result is held until the register frees.
//   max_depth is written on csr_wr_en; the user must write it only while idle,
//   as the block itself does not enforce it. A lower depth drops deeper levels at once.
//   Synchronous reset empties the book, sets max_depth to 10 and clears valids.
module price_level_book_side_top #(
   parameter int DEPTH = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [plbs_pkg::CMD_W-1:0]          req_command,
   input  logic [plbs_pkg::LEVEL_W-1:0]        req_level,
   input  logic signed [plbs_pkg::PRICE_W-1:0] req_price,
   input  logic [plbs_pkg::QTY_W-1:0]          req_quantity,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [plbs_pkg::STAT_W-1:0]         rsp_status,
   output logic [plbs_pkg::COUNT_W-1:0]        rsp_level_count,
   output logic signed [plbs_pkg::PRICE_W-1:0] rsp_top_price,
   output logic [plbs_pkg::QTY_W-1:0]          rsp_top_quantity,
   input  logic                                csr_wr_en,
   input  logic [plbs_pkg::COUNT_W-1:0]        csr_wr_data
);

   localparam logic [plbs_pkg::COUNT_W-1:0] DEPTH_CAP =
      (DEPTH > 15) ? 4'd15 : 4'(DEPTH);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_SHIFT  = 2'd2;
   localparam logic [1:0] S_REPORT = 2'd3;

   logic [1:0] state_ff, state_in;

   logic [plbs_pkg::CMD_W-1:0]   cmd_ff;
   logic [plbs_pkg::LEVEL_W-1:0] lvl_ff;
   logic [plbs_pkg::PRICE_W-1:0] price_ff;
   logic [plbs_pkg::QTY_W-1:0]   qty_ff;

   logic [plbs_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [plbs_pkg::COUNT_W-1:0] max_depth_ff, max_depth_in;
   logic [plbs_pkg::COUNT_W-1:0] rem_ff, rem_in;
   logic [plbs_pkg::STAT_W-1:0]  status_ff, status_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [plbs_pkg::STAT_W-1:0]  rsp_status_ff;
   logic [plbs_pkg::COUNT_W-1:0] rsp_count_ff;
   logic [plbs_pkg::PRICE_W-1:0] rsp_price_ff;
   logic [plbs_pkg::QTY_W-1:0]   rsp_qty_ff;

   plbs_pkg::cell_ctrl_type      ctrl;
   logic [plbs_pkg::PRICE_W-1:0] cell_price [DEPTH];
   logic [plbs_pkg::QTY_W-1:0]   cell_qty [DEPTH];
   logic [DEPTH-1:0]             cell_hit;

   logic                         accept, load_rsp, any_hit;
   logic                         lvl_nz, in_book, add_ok;
   logic [plbs_pkg::COUNT_W-1:0] depth, idx, new_depth;

   assign accept   = req_valid && req_ready;
   assign load_rsp = (state_ff == S_REPORT) && (!rsp_valid_ff || rsp_ready);
   assign any_hit  = |cell_hit;
   assign depth    = plbs_pkg::eff_depth(max_depth_ff, DEPTH_CAP);
   assign new_depth = plbs_pkg::eff_depth(csr_wr_data, DEPTH_CAP);

   assign lvl_nz  = (lvl_ff != '0);
   assign in_book = lvl_nz && (lvl_ff <= {4'b0000, count_ff});
   assign add_ok  = lvl_nz && (lvl_ff <= ({4'b0000, count_ff} + 8'd1));
   assign idx     = 4'(lvl_ff - 8'd1);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      status_in    = status_ff;
      max_depth_in = max_depth_ff;
      ctrl.mode    = plbs_pkg::MODE_HOLD;
      ctrl.idx     = idx;
      ctrl.price   = price_ff;
      ctrl.qty     = qty_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_EXEC;
         end
         S_EXEC: begin
            status_in = plbs_pkg::ST_OK;
            state_in  = S_REPORT;
            case (cmd_ff)
               plbs_pkg::CMD_ADD: begin
                  if (!add_ok) begin
                     status_in = plbs_pkg::ST_RANGE;
                  end else if (idx < depth) begin
                     ctrl.mode = plbs_pkg::MODE_INSERT;
                     if (count_ff < depth) count_in = count_ff + 4'd1;
                  end
               end
               plbs_pkg::CMD_UPDATE: begin
                  if (!in_book) status_in = plbs_pkg::ST_RANGE;
                  else if (!any_hit) status_in = plbs_pkg::ST_MISMATCH;
                  else ctrl.mode = plbs_pkg::MODE_UPDATE;
               end
               plbs_pkg::CMD_DELETE: begin
                  if (!in_book) begin
                     status_in = plbs_pkg::ST_RANGE;
                  end else if (!any_hit) begin
                     status_in = plbs_pkg::ST_MISMATCH;
                  end else begin
                     ctrl.mode = plbs_pkg::MODE_REMOVE;
                     count_in  = count_ff - 4'd1;
                  end
               end
               plbs_pkg::CMD_DELETE_FROM: begin
                  if (!in_book) begin
                     status_in = plbs_pkg::ST_RANGE;
                  end else begin
                     rem_in   = lvl_ff[plbs_pkg::COUNT_W-1:0];
                     state_in = S_SHIFT;
                  end
               end
               plbs_pkg::CMD_DELETE_THRU: begin
                  if (!in_book) status_in = plbs_pkg::ST_RANGE;
                  else count_in = idx;
               end
               plbs_pkg::CMD_CLEAR: begin
                  count_in = '0;
               end
               default: begin
                  status_in = plbs_pkg::ST_RANGE;
               end
            endcase
         end
         S_SHIFT: begin
            ctrl.mode = plbs_pkg::MODE_REMOVE;
            ctrl.idx  = '0;
            count_in  = count_ff - 4'd1;
            rem_in    = rem_ff - 4'd1;
            if (rem_ff == 4'd1) state_in = S_REPORT;
         end
         S_REPORT: begin
            if (load_rsp) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_wr_en) begin
         max_depth_in = csr_wr_data;
         if (count_in > new_depth) count_in = new_depth;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         max_depth_ff <= 4'd10;
         rem_ff       <= '0;
         status_ff    <= plbs_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         max_depth_ff <= max_depth_in;
         rem_ff       <= rem_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= req_command;
         lvl_ff   <= req_level;
         price_ff <= req_price;
         qty_ff   <= req_quantity;
      end
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
         rsp_price_ff  <= (count_ff != '0) ? cell_price[0] : '0;
         rsp_qty_ff    <= (count_ff != '0) ? cell_qty[0] : '0;
      end
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [plbs_pkg::PRICE_W-1:0] prev_p, next_p;
      logic [plbs_pkg::QTY_W-1:0]   prev_q, next_q;
      if (g == 0) begin : g_first
         assign prev_p = ctrl.price;
         assign prev_q = ctrl.qty;
      end else begin : g_mid
         assign prev_p = cell_price[g-1];
         assign prev_q = cell_qty[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
         assign next_p = cell_price[g];
         assign next_q = cell_qty[g];
      end else begin : g_inner
         assign next_p = cell_price[g+1];
         assign next_q = cell_qty[g+1];
      end
      plbs_cell #(.POS(g)) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .prev_price (prev_p),
         .prev_qty   (prev_q),
         .next_price (next_p),
         .next_qty   (next_q),
         .price      (cell_price[g]),
         .qty        (cell_qty[g]),
         .hit        (cell_hit[g])
      );
   end

   assign req_ready        = (state_ff == S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_level_count  = rsp_count_ff;
   assign rsp_top_price    = rsp_price_ff;
   assign rsp_top_quantity = rsp_qty_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= depth)
      else $error("level count above effective depth");

   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_count_ff == '0) |-> (rsp_price_ff == '0) && (rsp_qty_ff == '0))
      else $error("empty book reports a non-zero top level");

   a_shift_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (rem_ff != '0) && (rem_ff <= count_ff))
      else $error("shift loop count exceeds level count");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted request not executed");

endmodule
